[design/psgvgm_pkg.sv]
package psgvgm_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int CHAN_W       = $clog2(MAX_CHANNELS);
    localparam int COUNT_W      = 3;

    localparam int FREQ_W       = 16;
    localparam int VOL_W        = 8;
    localparam int ATT_W        = 4;
    localparam int CLOCK_W      = 22;
    localparam int STEP_W       = 8;
    localparam int KIND_W       = 2;
    localparam int SAMPLES_W    = 16;
    localparam int BYTE_W       = 8;

    localparam int CLOCK_SHIFT  = 4;
    localparam int DIVIDEND_W   = CLOCK_W - CLOCK_SHIFT;
    localparam int PRODUCT_W    = FREQ_W + STEP_W;
    localparam int PERIOD_W     = 10;
    localparam int MUL_CNT_W    = $clog2(STEP_W);
    localparam int DIV_CNT_W    = $clog2(DIVIDEND_W);

    localparam int MAX_BYTES    = 9;
    localparam int REMAIN_W     = $clog2(MAX_BYTES + 1);

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = CLOCK_W;

    localparam logic [CFG_INDEX_W-1:0] REG_PSG_CLOCK     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FREQ_STEP     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WAIT_KIND     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WAIT_SAMPLES  = 3'd4;

    localparam logic [CLOCK_W-1:0]   RESET_PSG_CLOCK     = 22'd3579545;
    localparam logic [STEP_W-1:0]    RESET_FREQ_STEP     = 8'd1;
    localparam logic [COUNT_W-1:0]   RESET_CHANNEL_COUNT = 3'd3;
    localparam logic [SAMPLES_W-1:0] RESET_WAIT_SAMPLES  = 16'd735;

    localparam logic [KIND_W-1:0] WAIT_FRAME_60 = 2'd0;
    localparam logic [KIND_W-1:0] WAIT_FRAME_50 = 2'd1;
    localparam logic [KIND_W-1:0] WAIT_SAMPLES  = 2'd2;

    localparam logic [BYTE_W-1:0] CMD_PSG_WRITE = 8'h50;
    localparam logic [BYTE_W-1:0] LATCH_ATTEN   = 8'h90;
    localparam logic [BYTE_W-1:0] LATCH_TONE    = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_WAIT_60   = 8'h62;
    localparam logic [BYTE_W-1:0] CMD_WAIT_50   = 8'h63;
    localparam logic [BYTE_W-1:0] CMD_WAIT_N    = 8'h61;
    localparam logic [BYTE_W-1:0] LOW_NIBBLE    = 8'h0F;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 10'd1023;
    localparam logic [ATT_W-1:0]    VOL_MAX     = 4'd15;

    typedef struct packed {
        logic [CHAN_W-1:0]    chan;
        logic [ATT_W-1:0]     atten;
        logic [PERIOD_W-1:0]  period;
        logic                 frame_end;
        logic [KIND_W-1:0]    wait_kind;
        logic [SAMPLES_W-1:0] wait_samples;
    } emit_load_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

[design/psgvgm_mul.sv]
module psgvgm_mul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [psgvgm_pkg::FREQ_W-1:0]     mcand,
    input  logic [psgvgm_pkg::STEP_W-1:0]     mplier,
    output logic                              done,
    output logic [psgvgm_pkg::PRODUCT_W-1:0]  product
);
    import psgvgm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PRODUCT_W-1:0] mcand_reg, mcand_next;
    logic [STEP_W-1:0]    mplier_reg, mplier_next;
    logic [PRODUCT_W-1:0] acc_reg, acc_next;

    // One multiplier bit per cycle: shift-and-add.
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = {{STEP_W{1'b0}}, mcand};
            mplier_next = mplier;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[PRODUCT_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[STEP_W-1:1]};
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(STEP_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[design/psgvgm_div.sv]
module psgvgm_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [psgvgm_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [psgvgm_pkg::PRODUCT_W-1:0]   divisor,
    output logic                               done,
    output logic [psgvgm_pkg::DIVIDEND_W-1:0]  quotient
);
    import psgvgm_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] num_reg, num_next;
    logic [PRODUCT_W-1:0]  rem_reg, rem_next;
    logic [PRODUCT_W-1:0]  dsr_reg, dsr_next;
    logic [PRODUCT_W:0]    trial;
    logic [PRODUCT_W:0]    diff;
    logic                  fits;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of num_reg while quotient bits shift in at the bottom.
    assign trial = {rem_reg, num_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[PRODUCT_W-1:0] : trial[PRODUCT_W-1:0];
            num_next = {num_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

[design/psgvgm_emit.sv]
module psgvgm_emit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  psgvgm_pkg::emit_load_t         frame,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [psgvgm_pkg::BYTE_W-1:0]  out_byte,
    output logic                           last,
    output logic                           finished
);
    import psgvgm_pkg::*;

    logic [MAX_BYTES-1:0][BYTE_W-1:0] shreg_reg, shreg_next;
    logic [REMAIN_W-1:0]              remain_reg, remain_next;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [REMAIN_W-1:0]              nbytes;
    logic [BYTE_W-1:0]                chan_bits;
    logic                             take;

    assign chan_bits = {1'b0, frame.chan, 5'b0};

    always_comb
    begin
        bytes    = '0;
        bytes[0] = CMD_PSG_WRITE;
        bytes[1] = LATCH_ATTEN | chan_bits | {4'b0, frame.atten};
        bytes[2] = CMD_PSG_WRITE;
        bytes[3] = LATCH_TONE | chan_bits | ({4'b0, frame.period[3:0]} & LOW_NIBBLE);
        bytes[4] = CMD_PSG_WRITE;
        bytes[5] = {2'b0, frame.period[PERIOD_W-1:4]};
        nbytes   = REMAIN_W'(6);
        if (frame.frame_end)
        begin
            unique case (frame.wait_kind)
                WAIT_FRAME_60:
                begin
                    bytes[6] = CMD_WAIT_60;
                    nbytes   = REMAIN_W'(7);
                end
                WAIT_FRAME_50:
                begin
                    bytes[6] = CMD_WAIT_50;
                    nbytes   = REMAIN_W'(7);
                end
                WAIT_SAMPLES:
                begin
                    bytes[6] = CMD_WAIT_N;
                    bytes[7] = frame.wait_samples[7:0];
                    bytes[8] = frame.wait_samples[15:8];
                    nbytes   = REMAIN_W'(9);
                end
                default:
                begin
                    nbytes = REMAIN_W'(6);
                end
            endcase
        end
    end

    assign out_valid = remain_reg != '0;
    assign take      = out_valid && out_ready;
    assign out_byte  = shreg_reg[0];
    assign last      = remain_reg == REMAIN_W'(1);
    assign finished  = take && last;

    // The frame's bytes leave one per transaction from the bottom of the line.
    always_comb
    begin
        shreg_next  = shreg_reg;
        remain_next = remain_reg;
        if (load)
        begin
            shreg_next  = bytes;
            remain_next = nbytes;
        end
        else if (take)
        begin
            shreg_next  = {{BYTE_W{1'b0}}, shreg_reg[MAX_BYTES-1:1]};
            remain_next = remain_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
        end
        else
        begin
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shreg_reg <= shreg_next;
    end

`ifndef NO_ASSERTIONS
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        finished |=> !out_valid)
        else $error("output still valid after the final byte");
    a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !out_valid)
        else $error("new frame loaded over pending bytes");
    a_remain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= REMAIN_W'(MAX_BYTES))
        else $error("byte count beyond the longest frame");
`endif

endmodule

[design/psg_vgm_command_encoder.sv]
// Channel   Direction  Handshake                    Payload
// in        input      in_valid / in_ready          frequency, volume
// out       output     out_valid / out_ready        out_byte, last
// cfg       input      cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One item at a time: a serial multiply, then a serial divide, then 6 to 9
// output bytes at one per transaction.
// Reset restores the register defaults and returns the channel counter to 0.
// A stall on the output holds the current byte; no new item is taken meanwhile.
module psg_vgm_command_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [psgvgm_pkg::FREQ_W-1:0]       frequency,
    input  logic [psgvgm_pkg::VOL_W-1:0]        volume,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [psgvgm_pkg::BYTE_W-1:0]       out_byte,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psgvgm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [psgvgm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import psgvgm_pkg::*;

    state_t               state_reg, state_next;
    logic [CLOCK_W-1:0]   psg_clock_reg;
    logic [STEP_W-1:0]    freq_step_reg;
    logic [COUNT_W-1:0]   channel_count_reg;
    logic [KIND_W-1:0]    wait_kind_reg;
    logic [SAMPLES_W-1:0] wait_samples_reg;
    logic [CHAN_W-1:0]    channel_index_reg, channel_index_next;
    logic [CHAN_W-1:0]    chan_reg, chan_next;
    logic                 frame_end_reg, frame_end_next;
    logic [VOL_W-1:0]     vol_reg, vol_next;
    logic                 zero_reg, zero_next;

    logic                 in_take;
    logic                 mul_done;
    logic [PRODUCT_W-1:0] product;
    logic                 div_done;
    logic [DIVIDEND_W-1:0] quotient;
    logic                 emit_done;
    logic [COUNT_W-1:0]   count_eff;
    logic                 is_frame_end;
    logic [PERIOD_W-1:0]  period;
    logic [ATT_W-1:0]     atten;
    emit_load_t           frame;

    assign in_ready  = state_reg == ST_IDLE;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        priority if (channel_count_reg == '0)
        begin
            count_eff = COUNT_W'(1);
        end
        else if (channel_count_reg > COUNT_W'(MAX_CHANNELS))
        begin
            count_eff = COUNT_W'(MAX_CHANNELS);
        end
        else
        begin
            count_eff = channel_count_reg;
        end
    end

    assign is_frame_end = ({1'b0, channel_index_reg} + 1'b1) >= count_eff;

    always_comb
    begin
        state_next         = state_reg;
        channel_index_next = channel_index_reg;
        chan_next          = chan_reg;
        frame_end_next     = frame_end_reg;
        vol_next           = vol_reg;
        zero_next          = zero_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next     = ST_MUL;
                    chan_next      = channel_index_reg;
                    frame_end_next = is_frame_end;
                    vol_next       = volume;
                    channel_index_next = is_frame_end ? '0 : channel_index_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_DIV;
                    zero_next  = product == '0;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            channel_index_reg <= '0;
            psg_clock_reg     <= RESET_PSG_CLOCK;
            freq_step_reg     <= RESET_FREQ_STEP;
            channel_count_reg <= RESET_CHANNEL_COUNT;
            wait_kind_reg     <= WAIT_FRAME_60;
            wait_samples_reg  <= RESET_WAIT_SAMPLES;
        end
        else
        begin
            state_reg         <= state_next;
            channel_index_reg <= channel_index_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_PSG_CLOCK:     psg_clock_reg     <= cfg_data;
                    REG_FREQ_STEP:     freq_step_reg     <= cfg_data[STEP_W-1:0];
                    REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[COUNT_W-1:0];
                    REG_WAIT_KIND:     wait_kind_reg     <= cfg_data[KIND_W-1:0];
                    REG_WAIT_SAMPLES:  wait_samples_reg  <= cfg_data[SAMPLES_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg      <= chan_next;
        frame_end_reg <= frame_end_next;
        vol_reg       <= vol_next;
        zero_reg      <= zero_next;
    end

    psgvgm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_take),
        .mcand   (frequency),
        .mplier  (freq_step_reg),
        .done    (mul_done),
        .product (product)
    );

    psgvgm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_done),
        .dividend (psg_clock_reg[CLOCK_W-1:CLOCK_SHIFT]),
        .divisor  (product),
        .done     (div_done),
        .quotient (quotient)
    );

    // A zero divisor and any quotient above the ten-bit range both give the
    // longest period.
    assign period = (zero_reg || (quotient[DIVIDEND_W-1:PERIOD_W] != '0))
                    ? PERIOD_MAX : quotient[PERIOD_W-1:0];
    assign atten  = (vol_reg[VOL_W-1:ATT_W] != '0) ? '0 : VOL_MAX - vol_reg[ATT_W-1:0];

    always_comb
    begin
        frame.chan         = chan_reg;
        frame.atten        = atten;
        frame.period       = period;
        frame.frame_end    = frame_end_reg;
        frame.wait_kind    = wait_kind_reg;
        frame.wait_samples = wait_samples_reg;
    end

    psgvgm_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (div_done),
        .frame     (frame),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last),
        .finished  (emit_done)
    );

`ifndef NO_ASSERTIONS
    a_out_only_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_EMIT)
        else $error("output valid outside the emit phase");
    a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_MUL)
        else $error("multiplier finished outside the multiply phase");
    a_div_feeds_output: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> out_valid)
        else $error("division finished without output bytes following");
`endif

endmodule
